>>> sv/ostt_pkg.sv
// Shared types and constants for the one-shot timer table.
package ostt_pkg;

	localparam int SLOT_COUNT_DEF = 16;

	localparam int TIME_W  = 48;
	localparam int ID_W    = 32;
	localparam int DELAY_W = 31;
	localparam int KIND_W  = 2;

	localparam logic [KIND_W-1:0] KIND_EXPIRED  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CREATED  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REJECTED = 2'd2;

	localparam logic REQ_TICK   = 1'b0;
	localparam logic REQ_CREATE = 1'b1;

	// one stored timer
	typedef struct packed {
		logic [TIME_W-1:0] end_ms;
		logic [TIME_W-1:0] arm_ms;
		logic [ID_W-1:0]   id;
	} slot_rec_t;

	// one result before it reaches the output register
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] arm_ms;
		logic [TIME_W-1:0] end_ms;
	} res_t;

endpackage

>>> sv/one_shot_timer_table_top.sv
// Top level of the one-shot timer table: slot sequencer, result staging and output register.
//
//  channel | dir | tdata                         | tuser          | tlast
//  s_axis  | in  | delay_ms[30:0]                | req_type[0]    | -
//  m_axis  | out | timer_id, start_time, end_time| result_kind    | last result
//
// After its transfer one item walks all SLOT_COUNT slots in order: an inactive slot is
// passed over or claimed, an active slot takes a registered read of the slot RAM and then
// the end <= now compare. A create then stages its acknowledgement, and at the end the
// final result is released and the block returns to idle. A free slot is claimed the first
// time the walk meets one. The walk stalls only while the staging register holds a result
// and the output register cannot take it. After reset the table is empty and the block
// is ready at once.
module one_shot_timer_table_top
	import ostt_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [31:0]  s_axis_tdata,  // [30:0] delay_ms, [31] zero
	input  logic [0:0]   s_axis_tuser,  // [0] req_type
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata,  // [31:0] timer_id, [79:32] start_time, [127:80] end_time
	output logic [1:0]   m_axis_tuser,  // [1:0] result_kind
	output logic         m_axis_tlast
);

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOT_COUNT - 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SLOT  = 3'd1;
	localparam logic [2:0] ST_CHK   = 3'd2;
	localparam logic [2:0] ST_ACK   = 3'd3;
	localparam logic [2:0] ST_FLUSH = 3'd4;

	logic [2:0]            state_q, state_d;
	logic [IDX_W-1:0]      idx_q;
	logic [SLOT_COUNT-1:0] act_q;
	logic [TIME_W-1:0]     now_q;
	logic [ID_W-1:0]       id_q;
	logic [TIME_W-1:0]     new_end_q;
	logic                  create_q;
	logic                  alloc_q;

	// one result held back until it is known whether it is the last
	logic pend_v_q;
	res_t pend_q;

	logic out_v_q;
	res_t out_q;
	logic out_last_q;

	logic      in_xfer;
	logic      out_free, can_emit;
	logic      rd_en, wr_en, adv, prod_v, flush, clr_act, set_act;
	res_t      prod_r;
	slot_rec_t rd_rec, wr_rec;
	logic      new_expired, rd_expired;

	ostt_slot_ram #(
		.DEPTH (SLOT_COUNT),
		.AW    (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (idx_q),
		.wdata (wr_rec),
		.re    (rd_en),
		.raddr (idx_q),
		.rdata (rd_rec)
	);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	assign out_free = !out_v_q || m_axis_tready;
	assign can_emit = !pend_v_q || out_free;

	assign new_expired = (new_end_q <= now_q);
	assign rd_expired  = (rd_rec.end_ms <= now_q);

	assign wr_rec.id     = id_q + 1'b1;
	assign wr_rec.arm_ms = now_q;
	assign wr_rec.end_ms = new_end_q;

	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		wr_en   = 1'b0;
		adv     = 1'b0;
		prod_v  = 1'b0;
		prod_r  = '0;
		flush   = 1'b0;
		clr_act = 1'b0;
		set_act = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					state_d = ST_SLOT;
				end
			end
			ST_SLOT: begin
				if (act_q[idx_q]) begin
					rd_en   = 1'b1;
					state_d = ST_CHK;
				end else if (create_q && !alloc_q) begin
					// claim this slot; a timer already due is reported and never marked active
					if (can_emit) begin
						wr_en = 1'b1;
						adv   = 1'b1;
						if (new_expired) begin
							prod_v = 1'b1;
							prod_r = '{kind: KIND_EXPIRED, id: wr_rec.id,
								arm_ms: now_q, end_ms: new_end_q};
						end else begin
							set_act = 1'b1;
						end
					end
				end else begin
					adv = 1'b1;
				end
			end
			ST_CHK: begin
				if (rd_expired) begin
					if (can_emit) begin
						prod_v  = 1'b1;
						prod_r  = '{kind: KIND_EXPIRED, id: rd_rec.id,
							arm_ms: rd_rec.arm_ms, end_ms: rd_rec.end_ms};
						clr_act = 1'b1;
						adv     = 1'b1;
					end
				end else begin
					adv = 1'b1;
				end
			end
			ST_ACK: begin
				if (can_emit) begin
					prod_v = 1'b1;
					if (alloc_q) begin
						prod_r = '{kind: KIND_CREATED, id: id_q,
							arm_ms: now_q, end_ms: new_end_q};
					end else begin
						prod_r = '{kind: KIND_REJECTED, id: '0, arm_ms: '0, end_ms: '0};
					end
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!pend_v_q || out_free) begin
					flush   = pend_v_q;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (adv) begin
			if (idx_q == IDX_LAST) begin
				state_d = create_q ? ST_ACK : ST_FLUSH;
			end else begin
				state_d = ST_SLOT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			idx_q    <= '0;
			act_q    <= '0;
			now_q    <= '0;
			id_q     <= '0;
			create_q <= 1'b0;
			alloc_q  <= 1'b0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_xfer) begin
				create_q <= (s_axis_tuser[0] == REQ_CREATE);
				alloc_q  <= 1'b0;
				idx_q    <= '0;
				if (s_axis_tuser[0] == REQ_TICK) begin
					now_q <= now_q + 1'b1;
				end
			end else if (adv && idx_q != IDX_LAST) begin
				idx_q <= idx_q + 1'b1;
			end
			if (wr_en) begin
				id_q    <= wr_rec.id;
				alloc_q <= 1'b1;
			end
			if (set_act) begin
				act_q[idx_q] <= 1'b1;
			end
			if (clr_act) begin
				act_q[idx_q] <= 1'b0;
			end
			if (prod_v) begin
				pend_v_q <= 1'b1;
			end else if (flush) begin
				pend_v_q <= 1'b0;
			end
			if ((prod_v && pend_v_q) || flush) begin
				out_v_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			new_end_q <= now_q + TIME_W'(s_axis_tdata[DELAY_W-1:0]);
		end
		if (prod_v) begin
			pend_q <= prod_r;
		end
		if (prod_v && pend_v_q) begin
			out_q      <= pend_q;
			out_last_q <= 1'b0;
		end else if (flush) begin
			out_q      <= pend_q;
			out_last_q <= 1'b1;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {out_q.end_ms, out_q.arm_ms, out_q.id};
	assign m_axis_tuser  = out_q.kind;
	assign m_axis_tlast  = out_last_q;

endmodule

>>> sv/ostt_slot_ram.sv
// Slot storage: id, start and end time per slot, one write and one registered read port.
module ostt_slot_ram
	import ostt_pkg::*;
#(
	parameter int DEPTH = SLOT_COUNT_DEF,
	parameter int AW    = 4
) (
	input  logic      clk,
	input  logic      we,
	input  logic [AW-1:0] waddr,
	input  slot_rec_t wdata,
	input  logic      re,
	input  logic [AW-1:0] raddr,
	output slot_rec_t rdata
);

	slot_rec_t mem_q [DEPTH];
	slot_rec_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
